FILE: design/mbg_pkg.sv
// Shared types, constants and helper functions of the maze backtracker generator.
// Used by the core and the port checker; depends on nothing.
package mbg_pkg;

    localparam int MAX_SIDE   = 16;
    localparam int MAX_CELLS  = 256;
    localparam int CELL_W     = 8;
    localparam int SIDE_W     = 5;
    localparam int RND_W      = 16;
    localparam int ADDR_W     = $clog2(MAX_CELLS);
    localparam int DEPTH_W    = $clog2(MAX_CELLS) + 1;
    localparam int ROW_W      = $clog2(MAX_SIDE);
    localparam int EPOCH_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(16);
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b1;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    typedef enum logic [1:0] {
        EV_CARVE     = 2'd0,
        EV_BACKTRACK = 2'd1,
        EV_FINISHED  = 2'd2,
        EV_RESTART   = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        DIR_TOP    = 2'd0,
        DIR_RIGHT  = 2'd1,
        DIR_BOTTOM = 2'd2,
        DIR_LEFT   = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic             opcode;
        logic [RND_W-1:0] random_value;
    } t_in_item;

    typedef struct packed {
        t_event            event_res;
        logic [CELL_W-1:0] from_cell;
        logic [CELL_W-1:0] to_cell;
        t_dir              direction;
    } t_out_item;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
    } t_rowcol;

    // Remainder by three: base-4 digits are each congruent to themselves mod 3.
    function automatic logic [1:0] f_mod3(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [3:0] s2;
        logic [2:0] s3;
        s = '0;
        for (int k = 0; k < RND_W / 2; k++) begin
            s = s + {3'b000, v[2*k +: 2]};
        end
        s2 = {1'b0, s[4:2]} + {2'b00, s[1:0]};
        s3 = {1'b0, s2[3:2]} + {1'b0, s2[1:0]};
        if (s3 >= 3'd3) begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

    // Row and column of a cell that lies inside the grid; the quotient then
    // stays below the side, so ROW_W restoring steps are enough.
    function automatic t_rowcol f_divmod(input logic [CELL_W-1:0] cell_idx,
                                         input logic [SIDE_W-1:0] side);
        logic [CELL_W:0] rem;
        logic [CELL_W:0] sub;
        t_rowcol         rc;
        rem = {1'b0, cell_idx};
        rc  = '0;
        for (int k = ROW_W - 1; k >= 0; k--) begin
            sub = {{(CELL_W + 1 - SIDE_W){1'b0}}, side} << k;
            if (rem >= sub) begin
                rem        = rem - sub;
                rc.row[k]  = 1'b1;
            end
        end
        rc.col = rem[ROW_W-1:0];
        return rc;
    endfunction

endpackage

FILE: design/maze_backtracker_generator_core.sv
// Top level of the maze backtracker generator: sequencer, walker state and memories.
// Depends on mbg_pkg and instantiates mbg_ram for the visited map and the cell stack.
//
// Randomized depth-first maze carving on a square grid of up to 16 x 16 cells.
// A step item passes the states RD0, RD1 and EXEC and a restart item only EXEC
// before the next item is taken; in RD0 and RD1 two copies of the visited map
// serve the four neighbour visited reads two at a time, and EXEC decides, waiting
// while a result is still stalled. Each item produces exactly one result item in
// an output register, so the next item is taken while a result still waits. The
// visited map is tagged with a restart epoch, so a restart clears it at once;
// after reset, and after every 255th restart when the epoch wraps, a clearing pass
// over all 256 entries takes no item (configuration writes are taken as ever).
module maze_backtracker_generator_core
    import mbg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_state r_state, n_state;

    logic [SIDE_W-1:0]  r_side_length;
    logic [CELL_W-1:0]  r_start_cell;
    logic [CELL_W-1:0]  r_cur, n_cur;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_op;
    logic [1:0]         r_rnd_lo;
    logic [1:0]         r_mod3;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_col;
    logic               r_top_free;
    logic               r_right_free;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [SIDE_W-1:0]  side_use;
    logic [2*SIDE_W-1:0] side_sq;
    logic [DEPTH_W-1:0] cells_use;
    logic [CELL_W-1:0]  side_cell;
    logic               cur_in_grid;
    logic               in_accept;
    logic               out_free;
    logic               exec_done;
    logic               epoch_wrap;
    t_rowcol            rowcol;

    logic               vis_we;
    logic [ADDR_W-1:0]  vis_waddr;
    logic [EPOCH_W-1:0] vis_wdata;
    logic               vis_re;
    logic [ADDR_W-1:0]  vis_raddr_a;
    logic [ADDR_W-1:0]  vis_raddr_b;
    logic [EPOCH_W-1:0] vis_q_a;
    logic [EPOCH_W-1:0] vis_q_b;
    logic               stk_we;
    logic               stk_re;
    logic [ADDR_W-1:0]  stk_raddr;
    logic [CELL_W-1:0]  stk_q;
    logic [DEPTH_W-1:0] depth_m1;

    logic [3:0]         cand;
    logic [2:0]         n_free;
    logic [1:0]         pick;
    logic [2:0]         seen;
    logic               found;
    t_dir               pick_dir;
    logic [CELL_W-1:0]  pick_cell;
    logic [CELL_W-1:0]  start_use;
    logic               push_ok;

    // Grid geometry in use.
    always_comb begin
        side_use = r_side_length;
        if (side_use < SIDE_MIN) begin
            side_use = SIDE_MIN;
        end
        if (side_use > SIDE_MAX) begin
            side_use = SIDE_MAX;
        end
        side_sq   = (2*SIDE_W)'(side_use) * (2*SIDE_W)'(side_use);
        cells_use = (side_sq > (2*SIDE_W)'(MAX_CELLS)) ? DEPTH_W'(MAX_CELLS)
                                                       : side_sq[DEPTH_W-1:0];
        side_cell = CELL_W'(side_use);
    end

    assign cur_in_grid = ({1'b0, r_cur} < cells_use);
    assign start_use   = ({1'b0, r_start_cell} < cells_use) ? r_start_cell : '0;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign exec_done   = (r_state == ST_EXEC) && out_free;
    assign epoch_wrap  = (r_epoch == '1);
    assign rowcol      = f_divmod(r_cur, side_use);
    assign depth_m1    = r_depth - DEPTH_W'(1);
    assign push_ok     = (r_depth < DEPTH_W'(MAX_CELLS));

    mbg_ram #(.WIDTH(EPOCH_W), .DEPTH(MAX_CELLS)) u_vis_a (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_re    (vis_re),
        .i_raddr (vis_raddr_a),
        .o_rdata (vis_q_a)
    );

    mbg_ram #(.WIDTH(EPOCH_W), .DEPTH(MAX_CELLS)) u_vis_b (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_re    (vis_re),
        .i_raddr (vis_raddr_b),
        .o_rdata (vis_q_b)
    );

    mbg_ram #(.WIDTH(CELL_W), .DEPTH(MAX_CELLS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[ADDR_W-1:0]),
        .i_wdata (r_cur),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    // Free neighbours in the order top, right, bottom, left. The top and right tags
    // were read in RD0 and registered in RD1; bottom and left sit on the RAM outputs.
    always_comb begin
        cand[0] = cur_in_grid && (r_row != '0) && r_top_free;
        cand[1] = cur_in_grid && ((SIDE_W'(r_col) + SIDE_W'(1)) < side_use) && r_right_free;
        cand[2] = cur_in_grid && ((SIDE_W'(r_row) + SIDE_W'(1)) < side_use)
                  && (vis_q_a != r_epoch);
        cand[3] = cur_in_grid && (r_col != '0) && (vis_q_b != r_epoch);
        n_free  = 3'($countones(cand));
        case (n_free)
            3'd2:    pick = {1'b0, r_rnd_lo[0]};
            3'd3:    pick = r_mod3;
            3'd4:    pick = r_rnd_lo;
            default: pick = 2'd0;
        endcase
        seen     = '0;
        found    = 1'b0;
        pick_dir = DIR_TOP;
        for (int k = 0; k < 4; k++) begin
            if (cand[k]) begin
                if (!found && (seen == {1'b0, pick})) begin
                    pick_dir = t_dir'(2'(k));
                    found    = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
        case (pick_dir)
            DIR_TOP:    pick_cell = r_cur - side_cell;
            DIR_RIGHT:  pick_cell = r_cur + CELL_W'(1);
            DIR_BOTTOM: pick_cell = r_cur + side_cell;
            default:    pick_cell = r_cur - CELL_W'(1);
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(MAX_CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.opcode == OP_RESTART) ? ST_EXEC : ST_RD0;
                end
            end
            ST_RD0: n_state = ST_RD1;
            ST_RD1: n_state = ST_EXEC;
            ST_EXEC: begin
                if (out_free) begin
                    n_state = (r_op == OP_RESTART && epoch_wrap) ? ST_CLEAR : ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Memory controls and input stall by state.
    always_comb begin
        o_in_stall  = 1'b1;
        vis_we      = 1'b0;
        vis_waddr   = r_cur;
        vis_wdata   = r_epoch;
        vis_re      = 1'b0;
        vis_raddr_a = r_cur - side_cell;
        vis_raddr_b = r_cur + CELL_W'(1);
        stk_we      = 1'b0;
        stk_re      = 1'b0;
        stk_raddr   = depth_m1[ADDR_W-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = r_clr_addr;
                vis_wdata = '0;
            end
            ST_IDLE: o_in_stall = 1'b0;
            ST_RD0: begin
                // Marking the current cell never collides with a neighbour read.
                vis_we = cur_in_grid;
                vis_re = 1'b1;
                stk_re = 1'b1;
            end
            ST_RD1: begin
                vis_re      = 1'b1;
                vis_raddr_a = r_cur + side_cell;
                vis_raddr_b = r_cur - CELL_W'(1);
            end
            ST_EXEC: begin
                stk_we = out_free && (r_op == OP_STEP) && (n_free != 3'd0) && push_ok;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // Walker update and result.
    always_comb begin
        n_cur       = r_cur;
        n_depth     = r_depth;
        n_epoch     = r_epoch;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (exec_done) begin
            n_out_valid     = 1'b1;
            n_out.from_cell = r_cur;
            n_out.direction = DIR_TOP;
            if (r_op == OP_RESTART) begin
                n_cur           = start_use;
                n_depth         = '0;
                n_epoch         = epoch_wrap ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
                n_out.event_res = EV_RESTART;
                n_out.to_cell   = start_use;
            end else if (n_free != 3'd0) begin
                n_cur           = pick_cell;
                n_depth         = push_ok ? r_depth + DEPTH_W'(1) : r_depth;
                n_out.event_res = EV_CARVE;
                n_out.to_cell   = pick_cell;
                n_out.direction = pick_dir;
            end else if (r_depth != '0) begin
                n_cur           = stk_q;
                n_depth         = depth_m1;
                n_out.event_res = EV_BACKTRACK;
                n_out.to_cell   = stk_q;
            end else begin
                n_out.event_res = EV_FINISHED;
                n_out.to_cell   = r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_side_length <= SIDE_RESET;
            r_start_cell  <= '0;
            r_cur         <= '0;
            r_depth       <= '0;
            r_epoch       <= EPOCH_W'(1);
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_depth     <= n_depth;
            r_epoch     <= n_epoch;
            r_out_valid <= n_out_valid;
            // The sweep ends on the last entry, so the address wraps back to zero.
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SIDE:  r_side_length <= i_cfg_data[SIDE_W-1:0];
                    CFG_START: r_start_cell  <= i_cfg_data[CELL_W-1:0];
                    default:   r_start_cell  <= r_start_cell;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_accept) begin
            r_op     <= i_in_data.opcode;
            r_rnd_lo <= i_in_data.random_value[1:0];
            r_mod3   <= f_mod3(i_in_data.random_value);
        end
        if (r_state == ST_RD0) begin
            r_row <= rowcol.row;
            r_col <= rowcol.col;
        end
        if (r_state == ST_RD1) begin
            r_top_free   <= (vis_q_a != r_epoch);
            r_right_free <= (vis_q_b != r_epoch);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/mbg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instantiated for the visited map copies and the cell stack.
module mbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/mbg_checker.sv
// Port-level checker for the maze backtracker generator core, bound to the top level.
// Depends on mbg_pkg for the item types and event codes.
module mbg_checker
    import mbg_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data
);

    // A stalled result item stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    // Items are worked one at a time, so an accepted item blocks the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken in back-to-back cycles");

    a_finish_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == EV_FINISHED
        |-> o_out_data.from_cell == o_out_data.to_cell)
        else $error("finished item moved the walker");

    a_carve_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == EV_CARVE
        |-> o_out_data.from_cell != o_out_data.to_cell)
        else $error("carve item did not move the walker");

    a_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res != EV_CARVE
        |-> o_out_data.direction == DIR_TOP)
        else $error("direction set on a non-carve item");

endmodule

bind maze_backtracker_generator_core mbg_checker u_mbg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
